[rtl/core/sha256_pkg.sv]
// Shared types, constants and round functions for the SHA-256 byte hasher.
// No dependencies.
`default_nettype none
package sha256_pkg;
    typedef enum logic [1:0] {
        OP_ABSORB        = 2'd0,
        OP_ABSORB_FINISH = 2'd1,
        OP_FINISH        = 2'd2,
        OP_UNUSED        = 2'd3
    } t_opcode;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic       store_byte;   // write byte at fill position, advance count
        logic       store_pad;    // write padding byte at fill position
        logic [7:0] pad_byte;
        logic       use_length;   // byte comes from the bit length
        logic       load_sched;   // load working vars from hash words
        logic       do_round;
        logic       add_hash;
        logic       reset_hash;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill_pos;
    } t_dp_status;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

[rtl/core/sha256_if.sv]
// Valid/ready channel interfaces for the SHA-256 byte hasher.
// Depends on nothing.
`default_nettype none
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    modport source (output valid, opcode, data_byte, input ready);
    modport sink (input valid, opcode, data_byte, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

[rtl/core/sha256_datapath.sv]
// Datapath: bit counter, byte-filled rolling schedule, round logic, hash words.
// Depends on sha256_pkg.
`default_nettype none
module sha256_datapath (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire sha256_pkg::t_dp_cmd    i_cmd,
    input  wire logic [7:0]             i_byte,
    input  wire logic [5:0]             i_round,
    input  wire logic [2:0]             i_word_sel,
    output sha256_pkg::t_dp_status      o_status,
    output logic [31:0]                 o_hash_word
);
    import sha256_pkg::*;

    logic [63:0] r_bits;
    logic [63:0] r_len;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  w_pos;
    logic [7:0]  w_wr_byte;
    logic [31:0] w_wr, w_s0, w_s1, w_t1, w_t2;

    assign w_pos = r_bits[8:3];
    assign o_status.fill_pos = w_pos;
    assign o_hash_word = r_h[i_word_sel];

    always_comb begin
        w_wr_byte = i_cmd.pad_byte;
        if (i_cmd.store_byte) begin
            w_wr_byte = i_byte;
        end else if (i_cmd.use_length) begin
            // big-endian length: position 56 takes bits 63:56
            w_wr_byte = r_len[{~w_pos[2:0], 3'b111} -: 8];
        end
    end

    // Schedule rolls: r_w[0] is always word for the current round.
    always_comb begin
        w_s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_wr = r_w[0] + w_s0 + r_w[9] + w_s1;
        w_t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[i_round] + r_w[0];
        w_t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Fill the schedule words byte by byte, big-endian within each word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte || i_cmd.store_pad) begin
            r_w[w_pos[5:2]][{~w_pos[1:0], 3'b000} +: 8] <= w_wr_byte;
        end else if (i_cmd.do_round) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= w_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sched) begin
            for (int j = 0; j < 8; j++) begin
                r_v[j] <= r_h[j];
            end
        end else if (i_cmd.do_round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_hash) begin
            r_h <= H_INIT;
        end else if (i_cmd.add_hash) begin
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= r_h[j] + r_v[j];
            end
        end
    end

    // Padding walks the fill position through the low counter bits; the
    // counter is cleared on reset_hash once the digest has gone out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_hash) begin
            r_bits <= '0;
        end else if (i_cmd.store_byte || i_cmd.store_pad) begin
            r_bits <= r_bits + 64'd8;
        end
    end
    // Length snapshot taken when padding starts (marker byte).
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_pad && i_cmd.pad_byte == PAD_MARKER && !i_cmd.use_length) begin
            r_len <= r_bits;
        end
    end
endmodule
`default_nettype wire

[rtl/core/sha256_ctrl.sv]
// Controller: sequences absorb, padding, 64 rounds and digest output.
// Depends on sha256_pkg.
`default_nettype none
module sha256_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic [1:0]             i_opcode,
    output logic                        o_in_ready,
    input  wire sha256_pkg::t_dp_status i_status,
    output sha256_pkg::t_dp_cmd         o_cmd,
    output logic [5:0]                  o_round,
    output logic [2:0]                  o_word_sel,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready
);
    import sha256_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_ROUND = 6'b000100,
        S_ADD   = 6'b001000,
        S_PAD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_round, n_round;
    logic [2:0] r_word, n_word;
    logic       r_fin, n_fin;     // finishing: padding in progress
    logic       r_last, n_last;   // final block being compressed
    logic [1:0] r_stage, n_stage; // 0 marker, 1 zeros, 2 length
    t_opcode    w_op;

    assign w_op = t_opcode'(i_opcode);
    assign o_round = r_round;
    assign o_word_sel = r_word;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_word = r_word;
        n_fin = r_fin;
        n_last = r_last;
        n_stage = r_stage;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (w_op)
                        OP_ABSORB, OP_ABSORB_FINISH: begin
                            o_cmd.store_byte = 1'b1;
                            n_fin = (w_op == OP_ABSORB_FINISH);
                            n_stage = 2'd0;
                            if (i_status.fill_pos == 6'd63) begin
                                n_state = S_LOAD;
                            end else if (w_op == OP_ABSORB_FINISH) begin
                                n_state = S_PAD;
                            end
                        end
                        OP_FINISH: begin
                            n_fin = 1'b1;
                            n_stage = 2'd0;
                            n_state = S_PAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_PAD: begin
                o_cmd.store_pad = 1'b1;
                unique case (r_stage)
                    2'd0: begin
                        o_cmd.pad_byte = PAD_MARKER;
                        n_stage = 2'd1;
                    end
                    2'd2: o_cmd.use_length = 1'b1;
                    default: o_cmd.pad_byte = 8'h00;
                endcase
                if (i_status.fill_pos == 6'd63) begin
                    n_state = S_LOAD;
                    n_last = (r_stage == 2'd2);
                end else if (i_status.fill_pos == 6'd55 && r_stage != 2'd2) begin
                    n_stage = 2'd2;
                end
            end
            S_LOAD: begin
                o_cmd.load_sched = 1'b1;
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.do_round = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add_hash = 1'b1;
                n_word = '0;
                if (r_last) begin
                    n_state = S_OUT;
                end else if (r_fin) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_word = r_word + 3'd1;
                    if (r_word == 3'd7) begin
                        o_cmd.reset_hash = 1'b1;
                        n_fin = 1'b0;
                        n_last = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_word <= '0;
            r_fin <= 1'b0;
            r_last <= 1'b0;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_word <= n_word;
            r_fin <= n_fin;
            r_last <= n_last;
            r_stage <= n_stage;
        end
    end
endmodule
`default_nettype wire

[rtl/core/sha256_byte_stream_hasher_unit.sv]
// SHA-256 byte hasher: one message byte per input word, 256-bit digest as
// eight output words. Each full 64-byte block is compressed by load, 64 rounds
// through the single round unit and hash add; a byte that does not complete a
// block is only stored. Finish pads one byte per cycle up to each block end and
// compresses, then presents the eight digest words, one per accepted output word.
// Depends on sha256_pkg, sha256_if, sha256_ctrl, sha256_datapath.
`default_nettype none
module sha256_byte_stream_hasher_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sha256_in_if.sink   i_in,
    sha256_out_if.source o_out
);
    import sha256_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [5:0] w_round;
    logic [2:0] w_word;

    sha256_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .i_opcode(i_in.opcode), .o_in_ready(i_in.ready),
        .i_status(w_status), .o_cmd(w_cmd), .o_round(w_round), .o_word_sel(w_word),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready)
    );

    sha256_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_byte(i_in.data_byte),
        .i_round(w_round), .i_word_sel(w_word), .o_status(w_status),
        .o_hash_word(o_out.digest_word)
    );

    assign o_out.word_index = w_word;
    assign o_out.last_word = (w_word == 3'd7);
endmodule
`default_nettype wire

[rtl/core/sha256_checker.sv]
// Port-level checker for the SHA-256 byte hasher, bound to the top level.
// Depends on sha256_byte_stream_hasher_unit, the bind target.
`default_nettype none
module sha256_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic [2:0] i_word_index,
    input wire logic i_last_word
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("input open during output");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_word == (i_word_index == 3'd7))) else $error("last flag");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_word |=>
        i_out_valid && i_word_index == $past(i_word_index) + 3'd1) else $error("index");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_word_index)) else $error("hold");
endmodule

bind sha256_byte_stream_hasher_unit sha256_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_word_index(o_out.word_index), .i_last_word(o_out.last_word)
);
`default_nettype wire

[tb/sha256_byte_stream_hasher_checker.sv]
// Digest checker for the SHA-256 byte hasher: watches both channels, computes
// the expected digest of every message and compares each output word.
// Depends on sha256_pkg and sha256_if.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha256_in_if      i_in,
    sha256_out_if     i_out,
    output int        o_fail_count,
    output int        o_pending
);
    import sha256_pkg::*;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_word;

    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    logic [63:0]  bit_count;
    t_digest_word digest_queue [$];
    int           fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = digest_queue.size();

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wr, w15, w2, t1, t2;
        for (int j = 0; j < 16; j++)
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        for (int j = 0; j < 8; j++) v[j] = hash_state[j];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                w15 = w[(r - 15) & 15];
                w2  = w[(r - 2) & 15];
                wr = w[r & 15] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
                     + w[(r - 7) & 15] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
                w[r & 15] = wr;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_state[j] += v[j];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int pos;
        pos = int'(bit_count[8:3]);
        msg_block[pos] = b;
        bit_count += 64'd8;
        if (pos == 63) compress_block();
    endtask

    task automatic finish_digest();
        int pos;
        logic [63:0] bits;
        t_digest_word dw;
        pos = int'(bit_count[8:3]);
        bits = bit_count;
        msg_block[pos] = PAD_MARKER;
        pos++;
        if (pos > 56) begin
            for (int j = pos; j < 64; j++) msg_block[j] = 8'h00;
            compress_block();
            pos = 0;
        end
        for (int j = pos; j < 56; j++) msg_block[j] = 8'h00;
        for (int j = 0; j < 8; j++) msg_block[56+j] = bits[63 - 8*j -: 8];
        compress_block();
        for (int j = 0; j < 8; j++) begin
            dw.digest_word = hash_state[j];
            dw.word_index  = 3'(j);
            dw.last_word   = (j == 7);
            digest_queue.push_back(dw);
        end
        for (int j = 0; j < 8; j++) hash_state[j] = H_INIT[j];
        bit_count = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: digest mismatch on %s: got %h, want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        bit_count = '0;
        for (int j = 0; j < 8; j++) hash_state[j] = H_INIT[j];
    end

    always @(posedge i_clk) begin
        t_digest_word want;
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (digest_queue.size() == 0) begin
                    report_mismatch("unexpected word", i_out.digest_word, 32'h0);
                end else begin
                    want = digest_queue.pop_front();
                    if (i_out.digest_word !== want.digest_word)
                        report_mismatch("digest_word", i_out.digest_word, want.digest_word);
                    if (i_out.word_index !== want.word_index)
                        report_mismatch("word_index", 32'(i_out.word_index),
                                        32'(want.word_index));
                    if (i_out.last_word !== want.last_word)
                        report_mismatch("last_word", 32'(i_out.last_word),
                                        32'(want.last_word));
                end
            end
            if (i_in.valid && i_in.ready) begin
                case (t_opcode'(i_in.opcode))
                    OP_ABSORB: absorb_byte(i_in.data_byte);
                    OP_ABSORB_FINISH: begin
                        absorb_byte(i_in.data_byte);
                        finish_digest();
                    end
                    OP_FINISH: finish_digest();
                    default: ;  // unused opcode: drop
                endcase
            end
        end
    end
endmodule

[tb/sha256_byte_stream_hasher_unit_test.sv]
// Top of the SHA-256 byte hasher test: clock, reset, byte stimulus with idle
// and stall phases, and the verdict. Depends on sha256_pkg, sha256_if, the
// checker and the hasher unit.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_unit_test;
    import sha256_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   sink_stall_pct;
    bit   hold_off;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_byte_stream_hasher_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    sha256_byte_stream_hasher_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off while the sender keeps going.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_word(input t_opcode op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One message of random bytes, ended by either finish form.
    task automatic send_message(input int len);
        for (int k = 0; k < len - 1; k++) send_word(OP_ABSORB, 8'($urandom));
        if (len > 0 && $urandom_range(1)) begin
            send_word(OP_ABSORB_FINISH, 8'($urandom));
        end else begin
            if (len > 0) send_word(OP_ABSORB, 8'($urandom));
            send_word(OP_FINISH, 8'($urandom));
        end
    endtask

    function automatic int pick_len();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return $urandom_range(0, 20);
        if (sel < 8) return $urandom_range(50, 70);
        return $urandom_range(110, 130);
    endfunction

    initial begin
        int phase_sent;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_ABSORB;
        in_ch.data_byte = 8'h00;
        hold_off        = 1'b0;
        send_idle_pct   = 0;
        sink_stall_pct  = 0;
        i_rst_n         = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty message, extreme bytes, unused opcode, padding overflow.
        send_word(OP_FINISH, 8'hff);
        send_word(OP_ABSORB_FINISH, 8'h00);
        send_word(OP_ABSORB_FINISH, 8'hff);
        send_word(OP_UNUSED, 8'h5a);
        send_word(OP_ABSORB, 8'haa);
        send_word(OP_UNUSED, 8'hff);
        send_word(OP_ABSORB_FINISH, 8'h55);
        send_message(56);
        send_message(64);

        // Long hold-off: sender keeps offering while the output is blocked.
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_message(40);
                send_message(10);
            end
        join

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 56; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 56; end
                default: begin send_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            phase_sent = 0;
            while (phase_sent < 30) begin
                int len;
                len = pick_len();
                if ($urandom_range(19) == 0) send_word(OP_UNUSED, 8'($urandom));
                send_message(len);
                phase_sent += len + 1;
            end
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
